/* hdl/sipq_pkg.sv */
// sipq_pkg: shared types and codes for the sorted-insert priority queue
// depends on nothing; imported by sipq_cell and the core top level
package sipq_pkg;

    localparam int KEY_W  = 16;
    localparam int WORD_W = 32;
    localparam int FILL_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0]  key;
        logic signed [WORD_W-1:0] word;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

/* hdl/sorted_insert_priority_queue_core.sv */
// sorted_insert_priority_queue_core: bounded priority queue as a row of shifting cells
// depends on sipq_pkg and sipq_cell
//
//  channel | valid   | stall   | fields
//  input   | i_valid | o_stall | i_operation, i_priority_req, i_payload
//  output  | o_valid | i_stall | o_status, o_out_priority, o_out_payload, o_fill_level
//
// one word per cycle while o_stall is low: every cell compares and shifts in parallel in the accept cycle
// the result is registered in the output register at accept and appears in the cycle after it
// input stalls only while a result is held and the output side stalls
// reset empties the queue at once; cell contents need no clearing
module sorted_insert_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_priority_req,
    input  logic signed [31:0] i_payload,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_out_priority,
    output logic signed [31:0] o_out_payload,
    output logic [4:0]         o_fill_level
);
    import sipq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [1:0]     n_status;
    logic [KEY_W-1:0]  r_opri;
    logic [KEY_W-1:0]  n_opri;
    logic [WORD_W-1:0] r_opay;
    logic [WORD_W-1:0] n_opay;
    logic [CW+FILL_W-1:0] w_fill;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_entry    w_new;
    t_entry    w_entry [DEPTH];
    logic      w_keeps [DEPTH];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctl.ins = w_accept && (i_operation == OP_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_operation == OP_REMOVE) && !w_empty;

    assign w_new.key  = i_priority_req;
    assign w_new.word = i_payload;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sipq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (CW'(g) < r_count),
            .i_new        (w_new),
            .i_left       ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g - 1]),
            .i_left_keeps ((g == 0) ? 1'b1 : w_keeps[(g == 0) ? 0 : g - 1]),
            .i_right      ((g == DEPTH - 1) ? w_entry[g]
                                            : w_entry[(g == DEPTH - 1) ? g : g + 1]),
            .o_entry      (w_entry[g]),
            .o_keeps      (w_keeps[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        n_opri   = '0;
        n_opay   = '0;
        unique case (i_operation)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_REMOVED;
                    n_opri   = w_entry[0].key;
                    n_opay   = w_entry[0].word;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_opri   <= n_opri;
            r_opay   <= n_opay;
        end
    end

    assign w_fill = (CW + FILL_W)'(r_count);

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_priority = r_opri;
    assign o_out_payload  = r_opay;
    assign o_fill_level   = w_fill[FILL_W-1:0];

endmodule

/* hdl/sipq_cell.sv */
// sipq_cell: one slot of the sorted chain, holds a key and its data word
// depends on sipq_pkg; instantiated in a row by sorted_insert_priority_queue_core
module sipq_cell (
    input  logic               i_clk,
    input  sipq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  sipq_pkg::t_entry   i_new,
    input  sipq_pkg::t_entry   i_left,
    input  logic               i_left_keeps,
    input  sipq_pkg::t_entry   i_right,
    output sipq_pkg::t_entry   o_entry,
    output logic               o_keeps
);
    import sipq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_keeps = i_occupied && (r_entry.key <= i_new.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            priority if (o_keeps) begin
                n_entry = r_entry;
            end else if (i_left_keeps) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for sorted_insert_priority_queue_core
// depends on sipq_pkg and the core; holds its own shadow queue as predictor
`timescale 1ns / 100ps

module tb_top;

    import sipq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int RANDOM_WORDS = 2000;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] prio;
        logic signed [31:0] word;
        logic [4:0]         fill;
    } t_result;

    typedef struct {
        logic               op;
        logic signed [15:0] key;
        logic signed [31:0] word;
        int                 reps;
        bit                 typed;
        logic [1:0]         e_status;
        logic signed [15:0] e_prio;
        logic signed [31:0] e_word;
        logic [4:0]         e_fill;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic               i_operation    = OP_INSERT;
    logic signed [15:0] i_priority_req = '0;
    logic signed [31:0] i_payload      = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [1:0]         o_status;
    logic signed [15:0] o_out_priority;
    logic signed [31:0] o_out_payload;
    logic [4:0]         o_fill_level;

    logic signed [15:0] shadow_keys  [QDEPTH];
    logic signed [31:0] shadow_words [QDEPTH];
    int                 shadow_count = 0;

    t_result awaited_results [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      send_rush      = 1'b0;
    bit      recv_rush      = 1'b0;

    // rows with a typed result are checked against it, the rest against the shadow queue
    t_stim_row directed_rows [11] = '{
        '{OP_REMOVE, 16'sd0,      32'sd0,         1,  1'b1, ST_EMPTY,    16'sd0,
          32'sd0,        5'd0},
        '{OP_INSERT, 16'sh7fff,   32'sh7fff_ffff, 1,  1'b1, ST_INSERTED, 16'sd0,
          32'sd0,        5'd1},
        '{OP_INSERT, -16'sh8000,  32'sh8000_0000, 1,  1'b1, ST_INSERTED, 16'sd0,
          32'sd0,        5'd2},
        '{OP_INSERT, 16'sd5,      32'sh0000_00a1, 1,  1'b0, ST_INSERTED, 16'sd0,
          32'sd0,        5'd0},
        '{OP_INSERT, 16'sd5,      32'sh0000_00a2, 1,  1'b0, ST_INSERTED, 16'sd0,
          32'sd0,        5'd0},
        '{OP_INSERT, 16'sd5,      32'shffff_ffff, 1,  1'b0, ST_INSERTED, 16'sd0,
          32'sd0,        5'd0},
        '{OP_REMOVE, 16'shffff,   32'shffff_ffff, 1,  1'b1, ST_REMOVED,  -16'sh8000,
          32'sh8000_0000, 5'd4},
        '{OP_REMOVE, 16'sd0,      32'sd0,         1,  1'b0, ST_REMOVED,  16'sd0,
          32'sd0,        5'd0},
        '{OP_REMOVE, 16'sd0,      32'sd0,         1,  1'b0, ST_REMOVED,  16'sd0,
          32'sd0,        5'd0},
        '{OP_INSERT, 16'sd100,    32'sh5a5a_0000, 14, 1'b0, ST_INSERTED, 16'sd0,
          32'sd0,        5'd0},
        '{OP_INSERT, -16'sh8000,  32'sh1234_5678, 1,  1'b1, ST_FULL,     16'sd0,
          32'sd0,        5'd16}
    };

    sorted_insert_priority_queue_core #(
        .DEPTH(QDEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload),
        .o_fill_level   (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result sorted_queue_step(input logic op,
                                                  input logic signed [15:0] key,
                                                  input logic signed [31:0] word);
        t_result res;
        int      pos;
        res = '0;
        if (op == OP_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_keys[k]  = shadow_keys[k-1];
                    shadow_words[k] = shadow_words[k-1];
                end
                shadow_keys[pos]  = key;
                shadow_words[pos] = word;
                shadow_count++;
                res.status = ST_INSERTED;
            end
        end else if (shadow_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.prio = shadow_keys[0];
            res.word = shadow_words[0];
            for (int k = 1; k < shadow_count; k++) begin
                shadow_keys[k-1]  = shadow_keys[k];
                shadow_words[k-1] = shadow_words[k];
            end
            shadow_count--;
            res.status = ST_REMOVED;
        end
        res.fill = 5'(shadow_count);
        return res;
    endfunction

    function automatic logic signed [15:0] draw_key(input int mode);
        logic signed [15:0] key;
        case (mode)
            0: key = 16'($urandom_range(0, 65535));
            1: key = 16'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0:       key = -16'sh8000;
                    1:       key = 16'sh7fff;
                    2:       key = -16'sd1;
                    3:       key = 16'sd0;
                    default: key = 16'($urandom_range(0, 65535));
                endcase
            end
        endcase
        return key;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0d ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_word(input logic op, input logic signed [15:0] key,
                             input logic signed [31:0] word, input bit typed,
                             input t_result typed_res);
        int      gap;
        t_result predicted;
        gap = send_rush ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_priority_req <= key;
        i_payload      <= word;
        do @(posedge i_clk); while (o_stall);
        predicted = sorted_queue_step(op, key, word);
        awaited_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls per word, with stretches of none
    initial begin
        t_result exp_res;
        int      hold;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result word with nothing awaited");
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (o_status !== exp_res.status)
                        report_mismatch($sformatf("status %0d, awaited %0d",
                                                  o_status, exp_res.status));
                    if (o_out_priority !== exp_res.prio)
                        report_mismatch($sformatf("priority %0d, awaited %0d",
                                                  o_out_priority, exp_res.prio));
                    if (o_out_payload !== exp_res.word)
                        report_mismatch($sformatf("payload %h, awaited %h",
                                                  o_out_payload, exp_res.word));
                    if (o_fill_level !== exp_res.fill)
                        report_mismatch($sformatf("fill %0d, awaited %0d",
                                                  o_fill_level, exp_res.fill));
                end
                if ($urandom_range(0, 39) == 0) recv_rush = !recv_rush;
                hold = recv_rush ? 0 : $urandom_range(0, 19);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("** sorted_insert_priority_queue_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int         sent;
        int         run_len;
        int         ins_pct;
        int         key_mode;
        logic       op;
        t_stim_row  row;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int i = 0; i < row.reps; i++) begin
                send_word(row.op, 16'(row.key - i), 32'(row.word + i), row.typed,
                          '{row.e_status, row.e_prio, row.e_word, row.e_fill});
            end
        end
        wait_drained();

        // phases lean towards filling, draining or churning the queue
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            run_len  = $urandom_range(20, 120);
            key_mode = $urandom_range(0, 2);
            send_rush = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       ins_pct = 90;
                1:       ins_pct = 10;
                default: ins_pct = 50;
            endcase
            for (int i = 0; i < run_len && sent < RANDOM_WORDS; i++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                send_word(op, draw_key(key_mode), 32'($urandom), 1'b0, '0);
                sent++;
                if (sent % 500 == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** sorted_insert_priority_queue_core: PASSED **");
        end else begin
            $display("** sorted_insert_priority_queue_core: FAILED **");
        end
        $finish;
    end

endmodule
